/* hdl/rsm_pkg.sv */
`default_nettype none

package rsm_pkg;

  localparam int ID_W         = 64;  // request identifier
  localparam int BEAM_W       = 4;   // beam_count and max_beam_width
  localparam int SLOT_FIELD_W = 6;   // slot field of a result
  localparam int COPY_W       = 9;   // copy_index field of a result
  localparam int IDX_W        = 10;  // slot index, wide enough for the largest table
  localparam int RESULT_LIMIT = 8;   // most results one item may cause
  localparam int MAX_BEAMS    = 8;   // ceiling for max_beam_width writes

  typedef enum logic [1:0] {
    OP_ADD,
    OP_LOOKUP,
    OP_REMOVE,
    OP_EXPAND
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_DUP,
    ST_FULL,
    ST_MISSING,
    ST_BEAMS
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   request_id;
    logic              is_context;
    logic [BEAM_W-1:0] beam_count;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [COPY_W-1:0]       copy_index;
    logic                    last;
  } res_t;

  // table update from the back end
  typedef struct packed {
    logic             alloc;
    logic             drop;
    logic [IDX_W-1:0] idx;
  } tbl_req_t;

  // registered search results of the table
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             full;
    logic [IDX_W-1:0] free_idx;
  } tbl_res_t;

endpackage

`default_nettype wire

/* hdl/rsm_front.sv */
`default_nettype none

module rsm_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,   // [63:0] request_id, [67:64] beam_count
  input  wire logic [2:0]   in_tuser,   // [1:0] op, [2] is_context
  output logic              q_valid,
  output rsm_pkg::cmd_t     q_cmd,
  input  wire logic         q_pop
);

  rsm_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  rsm_pkg::cmd_t in_cmd;
  logic          push;
  logic          pop;

  // decode the item into a command
  always_comb begin
    in_cmd.op         = rsm_pkg::op_t'(in_tuser[1:0]);
    in_cmd.request_id = in_tdata[rsm_pkg::ID_W-1:0];
    in_cmd.is_context = in_tuser[2];
    in_cmd.beam_count = in_tdata[rsm_pkg::ID_W +: rsm_pkg::BEAM_W];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_cmd;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

/* hdl/rsm_table.sv */
`default_nettype none

module rsm_table #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [rsm_pkg::ID_W-1:0]  key,
  input  rsm_pkg::tbl_req_t              req,
  output rsm_pkg::tbl_res_t              res
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0]     valid_r;
  logic [rsm_pkg::ID_W-1:0] owner_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     match_r;
  logic [NUM_SLOTS-1:0]     free_r;
  rsm_pkg::tbl_res_t        res_r;
  rsm_pkg::tbl_res_t        enc;
  logic [SLOT_W-1:0]        wr_idx;

  assign wr_idx = req.idx[SLOT_W-1:0];

  // compare stage: one comparator per slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_r[i] <= valid_r[i] && (owner_r[i] == key);
      free_r[i]  <= !valid_r[i];
    end
  end

  // encode stage: lowest set bit wins
  always_comb begin
    enc.hit      = |match_r;
    enc.full     = ~|free_r;
    enc.hit_idx  = '0;
    enc.free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) enc.hit_idx = rsm_pkg::IDX_W'(i);
      if (free_r[i]) enc.free_idx = rsm_pkg::IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= enc;
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (req.alloc) valid_r[wr_idx] <= 1'b1;
      if (req.drop) valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.alloc) owner_r[wr_idx] <= key;
  end

`ifndef SYNTHESIS
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.alloc |-> !valid_r[wr_idx])
    else $error("allocation into a used slot");
  a_drop_used: assert property (@(posedge clk) disable iff (!rst_n)
    req.drop |-> valid_r[wr_idx])
    else $error("freeing a slot that is not used");
  a_alloc_done: assert property (@(posedge clk) disable iff (!rst_n)
    req.alloc |=> valid_r[$past(wr_idx)])
    else $error("allocated slot not marked used");
`endif

endmodule

`default_nettype wire

/* hdl/rsm_back.sv */
`default_nettype none

module rsm_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rsm_pkg::BEAM_W-1:0]  max_beam_width,
  input  wire logic                        q_valid,
  input  rsm_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  output logic [rsm_pkg::ID_W-1:0]         key,
  output rsm_pkg::tbl_req_t                tbl_req,
  input  rsm_pkg::tbl_res_t                tbl_res,
  output logic                             res_vld,
  output rsm_pkg::res_t                    res,
  input  wire logic                        res_ready
);

  localparam int PROD_W = rsm_pkg::IDX_W + rsm_pkg::BEAM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_DEC,
    S_EMIT
  } state_t;

  state_t                           state_r;
  rsm_pkg::cmd_t                    cmd_r;
  rsm_pkg::res_t                    res_r;
  logic                             res_vld_r;
  logic [rsm_pkg::BEAM_W-1:0]       j_r;
  logic [rsm_pkg::SLOT_FIELD_W-1:0] slot_r;
  logic [rsm_pkg::COPY_W-1:0]       base_r;

  logic                             out_free;
  logic                             res_load;
  logic [PROD_W-1:0]                prod;
  logic [rsm_pkg::COPY_W-1:0]       base;
  logic                             dec_emit;
  logic                             dec_beams;
  rsm_pkg::res_t                    dec_res;
  rsm_pkg::res_t                    emit_res;
  logic                             emit_last;

  assign out_free = !res_vld_r || res_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign key      = cmd_r.request_id;
  assign res_vld  = res_vld_r;
  assign res      = res_r;

  // a new result is loaded into the output register this cycle
  assign res_load = out_free && ((state_r == S_DEC && dec_emit) || state_r == S_EMIT);

  assign prod = PROD_W'(tbl_res.hit_idx) * PROD_W'(max_beam_width);
  assign base = prod[rsm_pkg::COPY_W-1:0];

  // decision on the encoded table search
  always_comb begin
    dec_emit           = 1'b1;
    dec_beams          = 1'b0;
    dec_res.status     = rsm_pkg::ST_OK;
    dec_res.slot       = '0;
    dec_res.copy_index = '0;
    dec_res.last       = 1'b1;
    tbl_req.alloc      = 1'b0;
    tbl_req.drop       = 1'b0;
    tbl_req.idx        = tbl_res.hit_idx;
    if (cmd_r.op == rsm_pkg::OP_ADD) begin
      if (tbl_res.hit) begin
        dec_res.status = rsm_pkg::ST_DUP;
      end else if (tbl_res.full) begin
        dec_res.status = rsm_pkg::ST_FULL;
      end else begin
        dec_res.slot  = rsm_pkg::SLOT_FIELD_W'(tbl_res.free_idx);
        tbl_req.alloc = 1'b1;
        tbl_req.idx   = tbl_res.free_idx;
      end
    end else if (!tbl_res.hit) begin
      dec_res.status = rsm_pkg::ST_MISSING;
    end else begin
      case (cmd_r.op)
        rsm_pkg::OP_LOOKUP: begin
          dec_res.slot = rsm_pkg::SLOT_FIELD_W'(tbl_res.hit_idx);
        end
        rsm_pkg::OP_REMOVE: begin
          dec_res.slot = rsm_pkg::SLOT_FIELD_W'(tbl_res.hit_idx);
          tbl_req.drop = 1'b1;
        end
        rsm_pkg::OP_EXPAND: begin
          if (cmd_r.is_context) begin
            dec_res.slot       = rsm_pkg::SLOT_FIELD_W'(tbl_res.hit_idx);
            dec_res.copy_index = base;
          end else if (cmd_r.beam_count > max_beam_width ||
                       cmd_r.beam_count > rsm_pkg::BEAM_W'(rsm_pkg::RESULT_LIMIT)) begin
            dec_res.status = rsm_pkg::ST_BEAMS;
          end else begin
            // zero beams gives no result at all
            dec_emit  = 1'b0;
            dec_beams = (cmd_r.beam_count != '0);
          end
        end
        default: begin
          dec_res.slot = rsm_pkg::SLOT_FIELD_W'(tbl_res.hit_idx);
        end
      endcase
    end
    if (!(state_r == S_DEC && out_free)) begin
      tbl_req.alloc = 1'b0;
      tbl_req.drop  = 1'b0;
    end
  end

  assign emit_last           = (j_r + rsm_pkg::BEAM_W'(1)) == cmd_r.beam_count;
  assign emit_res.status     = rsm_pkg::ST_OK;
  assign emit_res.slot       = slot_r;
  assign emit_res.copy_index = base_r + rsm_pkg::COPY_W'(j_r);
  assign emit_res.last       = emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      if (res_load) res_vld_r <= 1'b1;
      else if (res_ready) res_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= S_ENC;
        S_ENC: state_r <= S_DEC;
        S_DEC: begin
          if (out_free) begin
            if (dec_emit) begin
              res_r     <= dec_res;
              state_r   <= S_IDLE;
            end else if (dec_beams) begin
              j_r     <= '0;
              slot_r  <= rsm_pkg::SLOT_FIELD_W'(tbl_res.hit_idx);
              base_r  <= base;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_r     <= emit_res;
            j_r       <= j_r + rsm_pkg::BEAM_W'(1);
            if (emit_last) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.status != rsm_pkg::ST_OK) |->
      (res_r.last && res_r.slot == '0 && res_r.copy_index == '0))
    else $error("error result carries slot or copy index");
`endif

endmodule

`default_nettype wire

/* hdl/request_slot_mapper_top.sv */
`default_nettype none

// Channel  Handshake                 Payload
// in_      in_tvalid / in_tready     tdata: request_id, beam_count; tuser: op, is_context
// out_     out_tvalid / out_tready   tdata: slot, copy_index; tuser: status; tlast: last
// cfg_     APB write/read, pready=1  register 0 at byte 0: max_beam_width
//
// An item passes through these back-end states in order before its first result: queue pop,
// identifier compare against every slot, priority encode, decision and table update.
// A generation expand latches its base in the decision state and then gives one
// result a cycle while the output is not stalled; any other item ends with its decision.
// The compare and encode stages of the slot table are registered.
// Reset clears every slot's used bit together; no clearing pass is needed.
// A two-item queue lets the input side keep accepting until it fills while results are stalled.

module request_slot_mapper_top #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,    // [63:0] request_id, [67:64] beam_count
  input  wire logic [2:0]  in_tuser,    // [1:0] op, [2] is_context
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [5:0] slot, [14:6] copy_index
  output logic [2:0]       out_tuser,   // [2:0] status
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [rsm_pkg::BEAM_W-1:0] MBW_CAP =
    (rsm_pkg::MAX_BEAMS > 15) ? rsm_pkg::BEAM_W'(15) : rsm_pkg::BEAM_W'(rsm_pkg::MAX_BEAMS);

  logic [rsm_pkg::BEAM_W-1:0] mbw_r;
  logic [rsm_pkg::BEAM_W-1:0] wr_val;
  logic                       cfg_wr;

  logic                       q_valid;
  rsm_pkg::cmd_t              q_cmd;
  logic                       q_pop;
  logic [rsm_pkg::ID_W-1:0]   key;
  rsm_pkg::tbl_req_t          tbl_req;
  rsm_pkg::tbl_res_t          tbl_res;
  rsm_pkg::res_t              res;

  // register file: one register, word index in paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_val     = cfg_pwdata[rsm_pkg::BEAM_W-1:0];
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(mbw_r) : 32'd0;

  // writes above the ceiling saturate; zero is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbw_r <= rsm_pkg::BEAM_W'(1);
    end else if (cfg_wr && cfg_paddr[2] == 1'b0) begin
      mbw_r <= (wr_val > MBW_CAP) ? MBW_CAP : wr_val;
    end
  end

  rsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  rsm_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key),
    .req   (tbl_req),
    .res   (tbl_res)
  );

  rsm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_beam_width (mbw_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .key            (key),
    .tbl_req        (tbl_req),
    .tbl_res        (tbl_res),
    .res_vld        (out_tvalid),
    .res            (res),
    .res_ready      (out_tready)
  );

  assign out_tdata = {1'b0, res.copy_index, res.slot};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

/* bench/request_slot_mapper_top_tb.sv */
`default_nettype none

module request_slot_mapper_top_tb;

  localparam int NUM_SLOTS   = 64;
  localparam int POOL_SIZE   = 96;    // a few more ids than slots, so the table fills
  localparam int LATENCY_PAD = 16;    // covers the back end's states plus up to 8 results
  localparam int LONG_HOLD   = 300;   // receiver hold-off, long enough to fill the queue
  localparam int IDLE_LIMIT  = 3000;  // cycles with no handshake at all before giving up
  localparam int MIXED_ITEMS = 48;

  // register byte addresses
  localparam logic [2:0] ADDR_MAX_BEAM_WIDTH = 3'd0;

  // ---------------------------------------------------------------------------
  // Slot table scoreboard: keeps its own copy of the table and the beam width,
  // works out the results of every accepted item and checks them in order.
  // ---------------------------------------------------------------------------
  class slot_map_scoreboard;
    bit                         used  [NUM_SLOTS];
    logic [rsm_pkg::ID_W-1:0]   owner [NUM_SLOTS];
    logic [rsm_pkg::BEAM_W-1:0] width;
    rsm_pkg::res_t              due_results[$];
    int                         errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      width  = 4'd1;
      errors = 0;
    endfunction

    // writes above the ceiling saturate, zero is kept
    function void set_width(logic [31:0] word);
      logic [rsm_pkg::BEAM_W-1:0] v;
      v = word[rsm_pkg::BEAM_W-1:0];
      if (v > rsm_pkg::MAX_BEAMS) v = rsm_pkg::BEAM_W'(rsm_pkg::MAX_BEAMS);
      width = v;
    endfunction

    function void push(rsm_pkg::status_t st, int s, int copy, bit last);
      rsm_pkg::res_t r;
      r.status     = st;
      r.slot       = s[rsm_pkg::SLOT_FIELD_W-1:0];
      r.copy_index = copy[rsm_pkg::COPY_W-1:0];
      r.last       = last;
      due_results.insert(due_results.size(), r);
    endfunction

    function int holder_of(logic [rsm_pkg::ID_W-1:0] id);
      int hit;
      hit = -1;
      for (int s = NUM_SLOTS - 1; s >= 0; s--)
        if (used[s] && owner[s] == id) hit = s;
      return hit;
    endfunction

    function void note_request(rsm_pkg::cmd_t c);
      int hit;
      int free_slot;
      int base;
      hit = holder_of(c.request_id);
      if (c.op == rsm_pkg::OP_ADD) begin
        free_slot = -1;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
          if (!used[s]) free_slot = s;
        if (hit >= 0) begin
          push(rsm_pkg::ST_DUP, 0, 0, 1'b1);
        end else if (free_slot < 0) begin
          push(rsm_pkg::ST_FULL, 0, 0, 1'b1);
        end else begin
          used[free_slot]  = 1'b1;
          owner[free_slot] = c.request_id;
          push(rsm_pkg::ST_OK, free_slot, 0, 1'b1);
        end
      end else if (hit < 0) begin
        push(rsm_pkg::ST_MISSING, 0, 0, 1'b1);
      end else begin
        case (c.op)
          rsm_pkg::OP_LOOKUP: begin
            push(rsm_pkg::ST_OK, hit, 0, 1'b1);
          end
          rsm_pkg::OP_REMOVE: begin
            used[hit] = 1'b0;
            push(rsm_pkg::ST_OK, hit, 0, 1'b1);
          end
          default: begin
            base = hit * int'(width);
            if (c.is_context) begin
              push(rsm_pkg::ST_OK, hit, base, 1'b1);
            end else if (c.beam_count > width || c.beam_count > rsm_pkg::RESULT_LIMIT) begin
              push(rsm_pkg::ST_BEAMS, 0, 0, 1'b1);
            end else begin
              // zero beams: nothing at all
              for (int j = 0; j < int'(c.beam_count); j++)
                push(rsm_pkg::ST_OK, hit, base + j, (j + 1) == int'(c.beam_count));
            end
          end
        endcase
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(rsm_pkg::res_t got);
      rsm_pkg::res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result: status %0d slot %0d copy %0d last %0b",
                         got.status, got.slot, got.copy_index, got.last));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.copy_index !== want.copy_index || got.last !== want.last)
        report($sformatf("got status %0d slot %0d copy %0d last %0b, want %0d %0d %0d %0b",
                         got.status, got.slot, got.copy_index, got.last,
                         want.status, want.slot, want.copy_index, want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input has a known value at time 0.
  // ---------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata    = '0;   // [63:0] request_id, [67:64] beam_count
  logic [2:0]  in_tuser    = '0;   // [1:0] op, [2] is_context
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // [5:0] slot, [14:6] copy_index
  logic [2:0]  out_tuser;          // [2:0] status
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  slot_map_scoreboard sb = new();

  logic [rsm_pkg::ID_W-1:0] id_pool [POOL_SIZE];
  bit                       no_gaps = 1'b0;   // both sides skip their random gaps while set
  rsm_pkg::res_t            seen;

  request_slot_mapper_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // mostly back to back, otherwise a random pause, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random tready, with two long hold-offs so the input queue
  // fills and in_tready drops while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    int hold_cnt;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 150 || taken == 600) begin
        out_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD) begin
          @(posedge clk);
          hold_cnt++;
        end
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // every accepted result goes straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.status     = rsm_pkg::status_t'(out_tuser);
      seen.slot       = out_tdata[5:0];
      seen.copy_index = out_tdata[14:6];
      seen.last       = out_tlast;
      sb.check_result(seen);
    end
  end

  // a stretch with no handshake of any kind means the block has hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. tvalid is left high after an item is taken so a following
  // item can go out on the next edge; anything else that passes time drops it.
  // ---------------------------------------------------------------------------
  task automatic offer_request(rsm_pkg::op_t op, logic [rsm_pkg::ID_W-1:0] id, logic ctx,
                               logic [rsm_pkg::BEAM_W-1:0] beams);
    rsm_pkg::cmd_t c;
    int            gap;
    c.op         = op;
    c.request_id = id;
    c.is_context = ctx;
    c.beam_count = beams;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, beams, id};
    in_tuser  <= {ctx, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(c);
  endtask

  // sender pauses until every expected result has come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // idle point: also covers an expand with no beams still in the back end
  task automatic settle();
    wait_all_results();
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // write the beam width (junk in the unused bits), then read it back
  task automatic write_width(logic [rsm_pkg::BEAM_W-1:0] v);
    logic [31:0] word;
    word = $urandom;
    word[rsm_pkg::BEAM_W-1:0] = v;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_MAX_BEAM_WIDTH;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_width(word);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[rsm_pkg::BEAM_W-1:0] !== sb.width)
      sb.report($sformatf("max_beam_width reads %0d, want %0d",
                          cfg_prdata[rsm_pkg::BEAM_W-1:0], sb.width));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // mixed traffic over the id pool, a little noise with ids never added
  task automatic run_mixed(int count);
    int                         r;
    rsm_pkg::op_t               op;
    logic [rsm_pkg::ID_W-1:0]   id;
    logic                       ctx;
    logic [rsm_pkg::BEAM_W-1:0] beams;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      op = rsm_pkg::OP_ADD;
      else if (r < 48) op = rsm_pkg::OP_LOOKUP;
      else if (r < 66) op = rsm_pkg::OP_REMOVE;
      else             op = rsm_pkg::OP_EXPAND;
      if ($urandom_range(0, 9) == 0) id = {$urandom, $urandom};
      else                           id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      ctx = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 10)                       beams = '0;
      else if (r < 25 || sb.width == 0) beams = rsm_pkg::BEAM_W'($urandom_range(0, 15));
      else                              beams = rsm_pkg::BEAM_W'($urandom_range(1, sb.width));
      offer_request(op, id, ctx, beams);
      if ($urandom_range(0, 99) < 3) wait_all_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [rsm_pkg::BEAM_W-1:0] phase_width [7];

  initial begin : stimulus
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};
    phase_width = '{4'd3, 4'd15, 4'd5, 4'd1, 4'd0, 4'd8, 4'd2};
    phase_width[6] = rsm_pkg::BEAM_W'($urandom_range(1, rsm_pkg::MAX_BEAMS));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset width of one
    offer_request(rsm_pkg::OP_ADD,    64'h0, 1'b0, 4'd0);                 // lowest slot
    offer_request(rsm_pkg::OP_ADD,    '1,    1'b0, 4'd0);
    offer_request(rsm_pkg::OP_ADD,    64'h0, 1'b1, 4'd15);                // already mapped
    offer_request(rsm_pkg::OP_LOOKUP, '1,    1'b0, 4'd0);
    offer_request(rsm_pkg::OP_LOOKUP, {32{2'b01}}, 1'b0, 4'd0);           // not there
    offer_request(rsm_pkg::OP_REMOVE, {32{2'b10}}, 1'b0, 4'd0);           // not there
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b0, 4'd15);  // missing beats beam check
    offer_request(rsm_pkg::OP_EXPAND, '1,    1'b1, 4'd0);                 // context base
    offer_request(rsm_pkg::OP_EXPAND, '1,    1'b0, 4'd1);
    offer_request(rsm_pkg::OP_EXPAND, '1,    1'b0, 4'd2);                 // beams above width
    offer_request(rsm_pkg::OP_EXPAND, '1,    1'b0, 4'd0);                 // no results at all
    offer_request(rsm_pkg::OP_REMOVE, 64'h0, 1'b0, 4'd0);
    offer_request(rsm_pkg::OP_LOOKUP, 64'h0, 1'b0, 4'd0);
    offer_request(rsm_pkg::OP_ADD,    64'h8000_0000_0000_0001, 1'b0, 4'd0); // reuses freed slot
    offer_request(rsm_pkg::OP_REMOVE, '1,    1'b0, 4'd0);
    settle();

    write_width(4'd8);
    offer_request(rsm_pkg::OP_ADD,    {32{2'b10}}, 1'b0, 4'd0);
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b0, 4'd8);           // full burst
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b0, 4'd9);           // above the limit
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b1, 4'd15);
    settle();

    write_width(4'd0);                                                    // every base is zero
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b1, 4'd0);
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b0, 4'd1);
    offer_request(rsm_pkg::OP_EXPAND, {32{2'b10}}, 1'b0, 4'd0);
    settle();

    // fill the table until adds are refused, then hit the top slot at full width
    write_width(4'd8);
    for (int i = 0; i < 70; i++) offer_request(rsm_pkg::OP_ADD, id_pool[i], 1'b0, 4'd0);
    if (sb.used[NUM_SLOTS-1]) begin
      offer_request(rsm_pkg::OP_EXPAND, sb.owner[NUM_SLOTS-1], 1'b0, 4'd8);
      offer_request(rsm_pkg::OP_EXPAND, sb.owner[NUM_SLOTS-1], 1'b1, 4'd3);
    end
    run_mixed(60);
    settle();

    // a range of widths; the saturating one runs with no gaps on either side
    for (int p = 0; p < 7; p++) begin
      no_gaps = (p == 1);
      write_width(phase_width[p]);
      run_mixed(MIXED_ITEMS);
      settle();
    end
    no_gaps = 1'b0;

    settle();
    if (sb.due_results.size() != 0)
      sb.report($sformatf("%0d results never came", sb.due_results.size()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/rsm_pkg.sv
hdl/rsm_front.sv
hdl/rsm_table.sv
hdl/rsm_back.sv
hdl/request_slot_mapper_top.sv
bench/request_slot_mapper_top_tb.sv
